@@ design/sha256_hasher_core_defines.svh @@
// Assertion macros used by the port-level checker of the SHA-256 hasher.
// No dependencies.
`ifndef SHA256_HASHER_CORE_DEFINES_SVH
`define SHA256_HASHER_CORE_DEFINES_SVH

// Check that a condition implies a consequence at the same edge.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence at the next edge.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sha_pkg.sv @@
// Package for the SHA-256 hasher: constants, round constants and round functions.
// No dependencies.
package sha_pkg;
	localparam int WordW = 32;
	localparam int DigestWords = 8;
	localparam int BlockWords = 16;
	localparam int Rounds = 64;

	typedef logic [WordW-1:0] word_t;

	// Control handed from the sequencer to the round datapath.
	typedef struct packed {
		logic load;   // copy hash into working variables
		logic round;  // run one round
		logic fold;   // add working variables into hash
		logic init;   // return hash to initial values
		logic [5:0] rnd;
	} rnd_ctl_t;

	function automatic word_t init_hash(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam word_t RoundK [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction
endpackage

@@ design/sha_round.sv @@
// One shared SHA-256 round unit with its message schedule window and hash state.
// Depends on sha_pkg.
module sha_round import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rnd_ctl_t ctl,
	input  word_t    blk [BlockWords],
	input  logic [2:0] rd_idx,
	output word_t    hash_rd
);
	word_t hash_q [DigestWords];
	word_t v_q [DigestWords];
	word_t w_q [BlockWords];
	word_t t1, t2, s1e, s0a, ch, maj, wt, wnew;

	// Form the round terms for the current round.
	always_comb begin
		wt   = w_q[0];
		s1e  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + s1e + ch + RoundK[ctl.rnd] + wt;
		s0a  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = s0a + maj;
		wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	end

	// Advance working variables and the schedule window.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < DigestWords; i++) v_q[i] <= hash_q[i];
			for (int i = 0; i < BlockWords; i++) w_q[i] <= blk[i];
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BlockWords-1] <= wnew;
		end
	end

	// Hold the chaining value; fold or reinitialize on command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DigestWords; i++) hash_q[i] <= init_hash(3'(i));
		end else if (ctl.init) begin
			for (int i = 0; i < DigestWords; i++) hash_q[i] <= init_hash(3'(i));
		end else if (ctl.fold) begin
			for (int i = 0; i < DigestWords; i++) hash_q[i] <= hash_q[i] + v_q[i];
		end
	end

	assign hash_rd = hash_q[rd_idx];
endmodule

@@ design/sha256_hasher_core.sv @@
// SHA-256 hasher top level: word intake, padding sequencer, digest output.
// Depends on sha_pkg and sha_round.
//
// Usage: the input channel (in_valid/in_ready) takes one big-endian 32-bit
// word per beat with valid_bytes and end_of_message. Words before the end
// count as four bytes. Sixteen words fill a block; a full block runs 64
// rounds on one shared round unit, one round per cycle, after a load step
// and before a fold of the working variables into the hash. On
// the end word the sequencer appends 0x80, zeros and the 64-bit bit length
// one word per cycle, running one or two final compressions, then presents
// the eight digest words on the output channel (out_valid/out_ready), index
// 0 first, last_word on the eighth. in_ready is low while a block
// compresses, padding runs or the digest drains; a receiver stall simply
// holds the current digest beat. After the eighth beat the hash returns to
// the initial values.
// Reset clears the fill count, bit count and sequencer and loads the
// initial hash values; no clearing pass is needed.
module sha256_hasher_core import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] msg_word,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StLoad = 3'd1;
	localparam logic [2:0] StRnd  = 3'd2;
	localparam logic [2:0] StFold = 3'd3;
	localparam logic [2:0] StPad  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0]  st_q;
	logic [5:0]  fill_q;      // byte fill, 0..63
	logic [63:0] bits_q;
	logic        fin_q;       // padding in progress
	logic        pad80_q;     // 0x80 still owed
	logic        spill_q;     // 0x80 landed past byte 55, length goes in the next block
	logic        tail_q;      // length words written into the block being compressed
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	word_t       blk_q [BlockWords];
	rnd_ctl_t    ctl;
	word_t       hash_rd;

	logic        acc;
	logic [2:0]  nb;
	logic [3:0]  widx;
	logic [6:0]  nfill;
	word_t       merged, padw;
	logic [5:0]  pfill;
	logic        lenw;

	assign in_ready = (st_q == StIdle);
	assign acc = in_valid && in_ready;

	// Count valid bytes of this beat.
	always_comb begin
		if (!end_of_message) nb = 3'd4;
		else if (valid_bytes > 3'd4) nb = 3'd4;
		else nb = valid_bytes;
	end

	assign widx = fill_q[5:2];

	// Merge new bytes into the partially filled word at the fill point.
	always_comb begin
		word_t keep;
		word_t mask;
		keep = blk_q[widx];
		mask = '1;
		case (fill_q[1:0])
			2'd0: mask = 32'h0;
			2'd1: mask = 32'hff000000;
			2'd2: mask = 32'hffff0000;
			default: mask = 32'hffffff00;
		endcase
		merged = (keep & mask) | ((msg_word >> (8 * fill_q[1:0])) & ~mask);
	end
	// Intake is word aligned except for the end word, so spill never occurs
	// before the end; byte counts above four are clamped to a full word.
	assign nfill = 7'(fill_q) + 7'(nb);

	// Length words go only into a block whose 0x80 already sits before byte 56.
	assign lenw = !pad80_q && !spill_q;

	// Build the next padding word at the current fill point.
	always_comb begin
		word_t m;
		word_t p;
		m = '1;
		p = '0;
		case (fill_q[1:0])
			2'd0: m = 32'h0;
			2'd1: m = 32'hff000000;
			2'd2: m = 32'hffff0000;
			default: m = 32'hffffff00;
		endcase
		if (pad80_q) begin
			case (fill_q[1:0])
				2'd0: p = 32'h80000000;
				2'd1: p = 32'h00800000;
				2'd2: p = 32'h00008000;
				default: p = 32'h00000080;
			endcase
		end
		if (lenw && fill_q == 6'd56) padw = bits_q[63:32];
		else if (lenw && fill_q == 6'd60) padw = bits_q[31:0];
		else padw = (blk_q[widx] & m) | p;
	end
	assign pfill = 6'({fill_q[5:2], 2'b00} + 6'd4);

	// Drive the round unit.
	always_comb begin
		ctl.load  = (st_q == StLoad);
		ctl.round = (st_q == StRnd);
		ctl.fold  = (st_q == StFold);
		ctl.init  = (st_q == StOut) && out_ready && (oidx_q == 3'd7);
		ctl.rnd   = rnd_q;
	end

	// Sequence intake, compression, padding and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= StIdle;
			fill_q  <= '0;
			bits_q  <= '0;
			fin_q   <= 1'b0;
			pad80_q <= 1'b0;
			spill_q <= 1'b0;
			tail_q  <= 1'b0;
			rnd_q   <= '0;
			oidx_q  <= '0;
		end else begin
			unique case (st_q)
				StIdle: begin
					if (acc) begin
						bits_q <= bits_q + 64'({nb, 3'b000});
						fill_q <= nfill[5:0];
						if (end_of_message) begin
							fin_q   <= 1'b1;
							pad80_q <= 1'b1;
							// an end word that fills the block compresses first, then pads
							st_q    <= nfill[6] ? StLoad : StPad;
						end else begin
							if (nfill[6]) st_q <= StLoad;
						end
					end
				end
				StPad: begin
					// one padding word per cycle
					if (pad80_q) begin
						pad80_q <= 1'b0;
						spill_q <= (fill_q >= 6'd56);
					end
					if (fill_q >= 6'd56 && lenw) begin
						fill_q <= pfill;
						if (fill_q == 6'd60) begin
							tail_q <= 1'b1;
							st_q   <= StLoad;
						end
					end else if (fill_q[5:2] == 4'd15) begin
						fill_q <= '0;
						st_q   <= StLoad;
					end else begin
						fill_q <= pfill;
					end
				end
				StLoad: begin
					rnd_q   <= '0;
					spill_q <= 1'b0;
					st_q    <= StRnd;
				end
				StRnd: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(Rounds - 1)) st_q <= StFold;
				end
				StFold: begin
					if (!fin_q) begin
						st_q <= StIdle;
					end else if (tail_q) begin
						tail_q <= 1'b0;
						st_q   <= StOut;
					end else begin
						st_q <= StPad;
					end
				end
				StOut: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							st_q   <= StIdle;
							fin_q  <= 1'b0;
							bits_q <= '0;
							fill_q <= '0;
						end
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	// Write block words on intake and padding.
	always_ff @(posedge clk) begin
		if (acc) blk_q[widx] <= merged;
		else if (st_q == StPad) blk_q[widx] <= padw;
	end

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk_q),
		.rd_idx (oidx_q),
		.hash_rd(hash_rd)
	);

	assign out_valid   = (st_q == StOut);
	assign digest_word = hash_rd;
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);
endmodule

@@ design/sha256_hasher_core_checker.sv @@
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_hasher_core_defines.svh.
`include "sha256_hasher_core_defines.svh"
module sha256_hasher_core_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_index,
	input logic       last_word
);
	`SHA_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input open while digest drains")
	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, out_valid, last_word == (word_index == 3'd7), "last flag off index")
	`SHA_ASSERT_NXT(a_idx_step, clk, arst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "digest index skipped")
	`SHA_ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(word_index), "stalled beat changed")
endmodule

bind sha256_hasher_core sha256_hasher_core_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .word_index(word_index),
	.last_word(last_word)
);

@@ dv/sha256_digest_checker.sv @@
// Checker for the SHA-256 hasher: watches both channels, predicts digests, compares.
// Depends on sha_pkg for the word type and round constants.
`timescale 1ns / 100ps
module sha256_digest_checker import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] msg_word,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          digests_pending,
	output int          messages_done
);
	typedef struct packed {
		word_t      data;
		logic [2:0] idx;
		logic       last;
	} digest_beat_t;

	digest_beat_t digest_queue[$];

	// predictor state
	word_t       chain[8];
	logic [7:0]  blk[64];
	int          fill;
	logic [63:0] msg_bits;

	function automatic word_t ror(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic run_block();
		word_t w[64];
		word_t v[8];
		word_t s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = chain;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic push_byte(logic [7:0] b);
		blk[fill] = b;
		fill++;
		if (fill == 64) begin
			run_block();
			fill = 0;
		end
	endtask

	task automatic restart();
		chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill = 0;
		msg_bits = '0;
	endtask

	// Absorb one accepted word; on message end pad and queue the digest.
	task automatic absorb_word(word_t data, logic [2:0] nb, logic eom);
		int n;
		logic [63:0] len;
		digest_beat_t d;
		n = !eom ? 4 : (nb > 4 ? 4 : int'(nb));
		for (int i = 0; i < n; i++)
			push_byte(data[31-8*i -: 8]);
		msg_bits += 64'(n * 8);
		if (eom) begin
			len = msg_bits;
			push_byte(8'h80);
			while (fill != 56)
				push_byte(8'h00);
			for (int i = 0; i < 8; i++)
				push_byte(len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.data = chain[i];
				d.idx = 3'(i);
				d.last = (i == 7);
				digest_queue.push_back(d);
			end
			restart();
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %0t: %s got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	assign digests_pending = digest_queue.size();

	// Sample both channels at the rising edge; clear the predictor in reset.
	always @(posedge clk) begin
		digest_beat_t e;
		if (!arst_n) begin
			fail_count = 0;
			messages_done = 0;
			restart();
		end else begin
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					report("unexpected beat", digest_word, 32'h0);
				end else begin
					e = digest_queue.pop_front();
					if (digest_word !== e.data) report("digest_word", digest_word, e.data);
					if (word_index !== e.idx)
						report("word_index", 32'(word_index), 32'(e.idx));
					if (last_word !== e.last)
						report("last_word", 32'(last_word), 32'(e.last));
					if (e.last) messages_done++;
				end
			end
			if (in_valid && in_ready)
				absorb_word(msg_word, valid_bytes, end_of_message);
		end
	end
endmodule

@@ dv/testbench.sv @@
// Stimulus and verdict for the SHA-256 hasher; checking lives in sha256_digest_checker.
// Depends on sha_pkg, sha256_hasher_core and sha256_digest_checker.
`timescale 1ns / 100ps
module testbench;
	import sha_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] msg_word;
	logic [2:0]  valid_bytes;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          digests_pending;
	int          messages_done;

	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_cycles;
	int  words_sent;
	logic hold_go;
	logic hold_used;

	sha256_hasher_core i_dut (.*);

	sha256_digest_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one word and hold it until accepted.
	task automatic send_word(word_t data, logic [2:0] nb, logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		msg_word <= data;
		valid_bytes <= nb;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// Send a message of nwords words; the end word carries nb valid bytes.
	task automatic send_message(int nwords, logic [2:0] nb);
		for (int i = 0; i < nwords - 1; i++)
			send_word($urandom, 3'($urandom), 1'b0);
		send_word($urandom, nb, 1'b1);
	endtask

	// Drop valid and wait until every expected digest beat has come.
	task automatic drain();
		in_valid <= 1'b0;
		while (digests_pending != 0)
			@(negedge clk);
	endtask

	// Receiver: random stall, or one long hold-off when asked.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			hold_used <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_cycles <= 400;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		msg_word = '0;
		valid_bytes = '0;
		end_of_message = 1'b0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		words_sent = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, each end-byte count, oversized counts, field extremes
		send_word(32'hffff_ffff, 3'd0, 1'b1);
		for (int nb = 1; nb < 8; nb++)
			send_word(32'h6162_6364, 3'(nb), 1'b1);
		send_word(32'h0000_0000, 3'd7, 1'b0);
		send_word(32'hffff_ffff, 3'd0, 1'b0);
		send_word(32'h8000_0001, 3'd4, 1'b1);
		// padding that fits the end block and padding crossing into a second block
		send_message(14, 3'd0);
		send_message(14, 3'd4);
		send_message(16, 3'd4);
		send_message(17, 3'd2);
		drain();

		// long receiver hold-off while words keep coming
		hold_go = 1'b1;
		send_message(20, 3'd3);
		send_message(3, 3'd1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 71 : 0;
			recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 27 : 0;
			for (int m = 0; m < 12; m++) begin
				if ($urandom_range(3) == 0)
					send_message($urandom_range(1, 4), 3'($urandom));
				else
					send_message($urandom_range(5, 20), 3'($urandom));
			end
			drain();
		end

		repeat (100) @(negedge clk);
		$display("covered %0d words in %0d messages, padding across one and two blocks",
			words_sent, messages_done);
		$display("stalls on both sides and one long receiver hold-off");
		if (fail_count == 0 && digests_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
